// ===== design/hebbian_weight_accumulator_assert.svh =====
// Assertion macros for the weight accumulator.
`ifndef HEBBIAN_WEIGHT_ACCUMULATOR_ASSERT_SVH
`define HEBBIAN_WEIGHT_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTH
// Check prop on every clock edge outside reset.
`define HWA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop on every clock edge, reset included.
`define HWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HWA_ASSERT(lbl, clk, rst, prop, msg)
`define HWA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/hwa_pkg.sv =====
package hwa_pkg;
   localparam int IMG_ROWS     = 16;
   localparam int IMG_COLS     = 16;
   localparam int MAX_PATTERNS = 64;
   localparam int NPIX         = IMG_ROWS * IMG_COLS;
   localparam int PIX_W        = $clog2(NPIX);
   localparam int WSIZE        = (NPIX * (NPIX - 1)) / 2;
   localparam int WADDR_W      = $clog2(WSIZE);
   localparam int WGT_W        = 8;
   localparam int TOT_W        = 7;
   localparam int PC_W         = 7;
   localparam int FRAC_W       = 15;
   localparam int DIV_W        = WGT_W + FRAC_W;
   localparam int DCNT_W       = $clog2(DIV_W);
   localparam int PIX_THRESH   = 127;

   localparam logic [1:0] REQ_TRAIN = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] RSP_DONE  = 2'd0;
   localparam logic [1:0] RSP_READ  = 2'd1;
   localparam logic [1:0] RSP_CLEAR = 2'd2;

   typedef struct packed {
      logic load_req;
      logic sweep_start;
      logic sweep;
      logic train_start;
      logic issue;
      logic finish;
      logic read_addr;
      logic read_latch;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic skip_loop;
      logic loop_last;
      logic last_pixel;
      logic sweep_last;
      logic div_done;
      logic out_free;
   } status_type;
endpackage

// ===== design/hwa_ram.sv =====
module hwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/hwa_div.sv =====
module hwa_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [hwa_pkg::DIV_W-1:0] dividend,
   input  logic [hwa_pkg::PC_W-1:0]  divisor,
   output logic [hwa_pkg::DIV_W-1:0] quotient,
   output logic                      done
);
   import hwa_pkg::*;

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [PC_W-1:0]   rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PC_W:0]     rem_sh;
   logic              ge;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? PC_W'(rem_sh - {1'b0, divisor}) : rem_sh[PC_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

// ===== design/hwa_ctrl.sv =====
module hwa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_type,
   output logic                req_ready,
   input  hwa_pkg::status_type status,
   output hwa_pkg::cmd_type    cmd
);
   import hwa_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE        = 10'b0000000001,
      ST_INIT_SWEEP  = 10'b0000000010,
      ST_CLR_SWEEP   = 10'b0000000100,
      ST_TRAIN_START = 10'b0000001000,
      ST_TRAIN_LOOP  = 10'b0000010000,
      ST_TRAIN_DRAIN = 10'b0000100000,
      ST_RD_ADDR     = 10'b0001000000,
      ST_RD_WAIT     = 10'b0010000000,
      ST_RD_DIV      = 10'b0100000000,
      ST_EMIT        = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_type)
                  REQ_TRAIN: state_in = ST_TRAIN_START;
                  REQ_READ:  state_in = ST_RD_ADDR;
                  REQ_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     state_in        = ST_CLR_SWEEP;
                  end
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLR_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_TRAIN_START: begin
            cmd.train_start = 1'b1;
            state_in = status.skip_loop ? ST_TRAIN_DRAIN : ST_TRAIN_LOOP;
         end
         ST_TRAIN_LOOP: begin
            cmd.issue = 1'b1;
            if (status.loop_last) begin
               state_in = ST_TRAIN_DRAIN;
            end
         end
         ST_TRAIN_DRAIN: begin
            cmd.finish = 1'b1;
            state_in = status.last_pixel ? ST_EMIT : ST_IDLE;
         end
         ST_RD_ADDR: begin
            cmd.read_addr = 1'b1;
            state_in      = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.read_latch = 1'b1;
            state_in       = ST_RD_DIV;
         end
         ST_RD_DIV: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== design/hwa_dp.sv =====
module hwa_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  hwa_pkg::cmd_type            cmd,
   output hwa_pkg::status_type         status,
   input  logic [1:0]                  req_type,
   input  logic [7:0]                  req_pixel_value,
   input  logic [7:0]                  req_row_index,
   input  logic [7:0]                  req_col_index,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [hwa_pkg::PC_W-1:0]    csr_pattern_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_resp_kind,
   output logic signed [7:0]           rsp_weight_sum,
   output logic signed [15:0]          rsp_weight_scaled,
   output logic [hwa_pkg::TOT_W-1:0]   rsp_patterns_stored,
   output logic                        rsp_overflow_flag
);
   import hwa_pkg::*;

   logic [1:0]              type_ff;
   logic                    bit_ff;
   logic [7:0]              row_ff, col_ff;
   logic [PC_W-1:0]         pc_ff;
   logic [PIX_W-1:0]        pos_ff, pos_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic                    ovf_ff, ovf_in;
   logic                    ign_ff, ign_in;
   logic [WADDR_W-1:0]      cnt_ff, cnt_in;
   logic [WADDR_W-1:0]      base_ff;
   logic                    pipe_ff;
   logic [WADDR_W-1:0]      paddr_ff;
   logic                    idx_ok_ff;
   logic signed [WGT_W-1:0] sum_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              kind_ff;
   logic signed [7:0]       wsum_ff;
   logic signed [15:0]      wscaled_ff;
   logic [TOT_W-1:0]        stored_ff;
   logic                    oflag_ff;

   logic                    ign_now;
   logic [2*PIX_W-1:0]      base_prod;
   logic [PIX_W-1:0]        hi, lo;
   logic                    idx_ok;
   logic [2*PIX_W-1:0]      tri_prod;
   logic [WADDR_W-1:0]      tri_addr;
   logic                    w_en;
   logic [WADDR_W-1:0]      w_addr, r_addr;
   logic [WGT_W-1:0]        w_data, w_rd;
   logic                    b_rd;
   logic signed [WGT_W-1:0] sum_in;
   logic [WGT_W-1:0]        sum_mag;
   logic [DIV_W-1:0]        quo;
   logic                    div_done;
   logic signed [15:0]      scaled;
   logic [PC_W-1:0]         divisor;

   // Training address math.
   assign ign_now   = (pos_ff == '0) ? (32'(total_ff) >= MAX_PATTERNS) : ign_ff;
   assign base_prod = pos_ff * (pos_ff - 1'b1);

   // Read address math: fold onto the lower triangle.
   always_comb begin
      idx_ok   = (32'(row_ff) < NPIX) && (32'(col_ff) < NPIX) && (row_ff != col_ff);
      hi       = (row_ff > col_ff) ? row_ff[PIX_W-1:0] : col_ff[PIX_W-1:0];
      lo       = (row_ff > col_ff) ? col_ff[PIX_W-1:0] : row_ff[PIX_W-1:0];
      tri_prod = hi * (hi - 1'b1);
      tri_addr = WADDR_W'(tri_prod >> 1) + WADDR_W'(lo);
   end

   // Store ports: sweep writes zero, the training pipe writes back.
   always_comb begin
      w_en   = cmd.sweep | pipe_ff;
      w_addr = cmd.sweep ? cnt_ff : paddr_ff;
      w_data = cmd.sweep ? '0 :
               ((b_rd == bit_ff) ? w_rd + 1'b1 : w_rd - 1'b1);
      r_addr = cmd.read_addr ? tri_addr : base_ff + cnt_ff;
   end

   hwa_ram #(.WIDTH(WGT_W), .DEPTH(WSIZE)) u_wgt (
      .clock   (clock),
      .wr_en   (w_en),
      .wr_addr (w_addr),
      .wr_data (w_data),
      .rd_addr (r_addr),
      .rd_data (w_rd)
   );

   hwa_ram #(.WIDTH(1), .DEPTH(NPIX)) u_bits (
      .clock   (clock),
      .wr_en   (cmd.train_start),
      .wr_addr (pos_ff),
      .wr_data (bit_ff),
      .rd_addr (cnt_ff[PIX_W-1:0]),
      .rd_data (b_rd)
   );

   // Scaling divider.
   assign divisor = (pc_ff == '0) ? PC_W'(1) : pc_ff;
   assign sum_in  = idx_ok_ff ? signed'(w_rd) : '0;
   assign sum_mag = sum_in[WGT_W-1] ? WGT_W'(-sum_in) : WGT_W'(sum_in);

   hwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.read_latch),
      .dividend ({sum_mag, FRAC_W'(0)}),
      .divisor  (divisor),
      .quotient (quo),
      .done     (div_done)
   );

   // Sign and saturate the quotient.
   always_comb begin
      if (sum_ff[WGT_W-1]) begin
         scaled = (quo >= DIV_W'(32768)) ? 16'sh8000 : 16'(-signed'({1'b0, quo}));
      end else begin
         scaled = (quo > DIV_W'(32767)) ? 16'sh7fff : 16'(quo);
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      ign_in       = ign_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.sweep_start) begin
         pos_in   = '0;
         total_in = '0;
         ovf_in   = 1'b0;
         ign_in   = 1'b0;
         cnt_in   = '0;
      end
      if (cmd.sweep || cmd.issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.train_start) begin
         cnt_in = '0;
         ign_in = ign_now;
         if (pos_ff == '0 && ign_now) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         pos_in = pos_ff + 1'b1;
         if (32'(pos_ff) == NPIX - 1) begin
            pos_in = '0;
            if (!ign_ff) begin
               total_in = total_ff + 1'b1;
            end
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_W'(1);
         pos_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         ign_ff       <= 1'b0;
         cnt_ff       <= '0;
         pipe_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            pc_ff <= csr_pattern_count;
         end
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         ign_ff       <= ign_in;
         cnt_ff       <= cnt_in;
         pipe_ff      <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_req) begin
         type_ff <= req_type;
         bit_ff  <= 32'(req_pixel_value) > PIX_THRESH;
         row_ff  <= req_row_index;
         col_ff  <= req_col_index;
      end
      if (cmd.train_start) begin
         base_ff <= WADDR_W'(base_prod >> 1);
      end
      paddr_ff <= base_ff + cnt_ff;
      if (cmd.read_addr) begin
         idx_ok_ff <= idx_ok;
      end
      if (cmd.read_latch) begin
         sum_ff <= sum_in;
      end
      if (cmd.emit) begin
         kind_ff    <= (type_ff == REQ_READ) ? RSP_READ :
                       (type_ff == REQ_CLEAR) ? RSP_CLEAR : RSP_DONE;
         wsum_ff    <= (type_ff == REQ_READ) ? 8'(sum_ff) : '0;
         wscaled_ff <= (type_ff == REQ_READ) ? scaled : '0;
         stored_ff  <= total_ff;
         oflag_ff   <= ovf_ff;
      end
   end

   always_comb begin
      status.skip_loop  = (pos_ff == '0) || ign_now;
      status.loop_last  = cnt_ff[PIX_W-1:0] == pos_ff - 1'b1;
      status.last_pixel = 32'(pos_ff) == NPIX - 1;
      status.sweep_last = 32'(cnt_ff) == WSIZE - 1;
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_resp_kind       = kind_ff;
   assign rsp_weight_sum      = wsum_ff;
   assign rsp_weight_scaled   = wscaled_ff;
   assign rsp_patterns_stored = stored_ff;
   assign rsp_overflow_flag   = oflag_ff;
endmodule

// ===== design/hebbian_weight_accumulator.sv =====
// Hebbian weight accumulator: outer-product learning over 16x16 bipolar images.
// Request channel (req_*): code 0 trains one pixel (streamed row by row),
// code 1 reads weight (row_index, col_index), code 2 clears the store; code 3
// is taken and dropped. One request is in work at a time.
// Response channel (rsp_*): one response at the end of each pattern, for each
// read and for each clear. It sits in an output register, so the next request
// is taken while a response still waits; a stalled receiver holds the block
// only when the next response is ready to leave.
// Cost: pixel p of a kept pattern does one read-modify-write of the weight
// RAM per earlier pixel; a read waits on the bit-serial Q1.15 divider; a
// clear zeroes one RAM word per cycle. Patterns past 64 are consumed, ignored
// and flagged.
// Reset: synchronous; a clearing pass zeroes the weight RAM, req_ready stays
// low meanwhile. csr_* writes pattern_count; write it only while no request
// is in work, since a read divides by the live value.
module hebbian_weight_accumulator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [7:0]                req_pixel_value,
   input  logic [7:0]                req_row_index,
   input  logic [7:0]                req_col_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_resp_kind,
   output logic signed [7:0]         rsp_weight_sum,
   output logic signed [15:0]        rsp_weight_scaled,
   output logic [hwa_pkg::TOT_W-1:0] rsp_patterns_stored,
   output logic                      rsp_overflow_flag,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [hwa_pkg::PC_W-1:0]  csr_pattern_count
);
   import hwa_pkg::*;

`include "hebbian_weight_accumulator_assert.svh"

   cmd_type    cmd;
   status_type status;

   // Sequence each request through sweep, train, read and response steps.
   hwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the weight RAM, pixel bits, counters, divider and response register.
   hwa_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_type            (req_type),
      .req_pixel_value     (req_pixel_value),
      .req_row_index       (req_row_index),
      .req_col_index       (req_col_index),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_pattern_count   (csr_pattern_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_resp_kind       (rsp_resp_kind),
      .rsp_weight_sum      (rsp_weight_sum),
      .rsp_weight_scaled   (rsp_weight_scaled),
      .rsp_patterns_stored (rsp_patterns_stored),
      .rsp_overflow_flag   (rsp_overflow_flag)
   );

   // A real request leaves idle, so the next one waits.
   `HWA_ASSERT(a_one_in_work, clock, reset, (req_valid && req_ready && req_type != 2'd3) |=> !req_ready, "request taken while another is in work")
   // A response only appears when the controller emits one.
   `HWA_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid) |-> $past(cmd.emit), "response without emit")
   // Never overwrite a response that is still waiting.
   `HWA_ASSERT(a_no_overwrite, clock, reset, (cmd.emit && rsp_valid) |-> rsp_ready, "pending response overwritten")
   // Pattern count never passes the limit.
   `HWA_ASSERT(a_count_limit, clock, reset, rsp_valid |-> (32'(rsp_patterns_stored) <= MAX_PATTERNS), "pattern count beyond limit")
   // No request is taken in the cycle after reset (clearing pass runs).
   `HWA_ASSERT_ALWAYS(a_reset_sweep, clock, $past(reset) |-> !req_ready, "request taken during clearing pass")
endmodule

// ===== test/hebbian_weight_accumulator_check.sv =====
`timescale 1ns / 100ps

module hebbian_weight_accumulator_check
   import hwa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [7:0]          req_pixel_value,
   input  logic [7:0]          req_row_index,
   input  logic [7:0]          req_col_index,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_resp_kind,
   input  logic signed [7:0]   rsp_weight_sum,
   input  logic signed [15:0]  rsp_weight_scaled,
   input  logic [TOT_W-1:0]    rsp_patterns_stored,
   input  logic                rsp_overflow_flag,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [PC_W-1:0]     csr_pattern_count,
   output int                  mismatches,
   output int                  pending
);

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [7:0]  sum;
      logic signed [15:0] scaled;
      logic [TOT_W-1:0]   stored;
      logic               ovf;
   } answer_t;

   int             weight_tally [WSIZE];
   bit             pixel_sign [NPIX];
   int             pixel_pos;
   int             trained;
   bit             ovf_seen;
   bit             skipping;
   logic [PC_W-1:0] divisor;
   answer_t        answers [$];

   function automatic int tri_slot(input int hi, input int lo);
      return hi * (hi - 1) / 2 + lo;
   endfunction

   task automatic learn_pixel(input logic [7:0] pix);
      int  p;
      bit  sgn;
      answer_t a;
      p = pixel_pos;
      sgn = (pix > PIX_THRESH);
      if (p == 0) begin
         skipping = (trained >= MAX_PATTERNS);
         if (skipping) ovf_seen = 1;
      end
      if (!skipping)
         for (int k = 0; k < p; k++)
            weight_tally[tri_slot(p, k)] += (pixel_sign[k] == sgn) ? 1 : -1;
      pixel_sign[p] = sgn;
      p++;
      if (p >= NPIX) begin
         pixel_pos = 0;
         if (!skipping) trained++;
         a = '{RSP_DONE, 8'sd0, 16'sd0, trained[TOT_W-1:0], ovf_seen};
         answers.push_back(a);
      end else begin
         pixel_pos = p;
      end
   endtask

   task automatic read_weight(input int r, input int c);
      int      s;
      longint  q;
      longint  dv;
      answer_t a;
      s = 0;
      if (r < NPIX && c < NPIX && r != c)
         s = weight_tally[(r > c) ? tri_slot(r, c) : tri_slot(c, r)];
      dv = (divisor == 0) ? 64'sd1 : longint'(divisor);
      q = (longint'(s) * 64'sd32768) / dv;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      if (s > 127) s = 127;
      if (s < -128) s = -128;
      a = '{RSP_READ, s[7:0], q[15:0], trained[TOT_W-1:0], ovf_seen};
      answers.push_back(a);
   endtask

   task automatic wipe_store();
      foreach (weight_tally[i]) weight_tally[i] = 0;
      pixel_pos = 0;
      trained = 0;
      ovf_seen = 0;
      skipping = 0;
      answers.push_back('{RSP_CLEAR, 8'sd0, 16'sd0, '0, 1'b0});
   endtask

   initial begin
      foreach (weight_tally[i]) weight_tally[i] = 0;
      pixel_pos = 0;
      trained = 0;
      ovf_seen = 0;
      skipping = 0;
      divisor = 1;
      mismatches = 0;
   end

   assign pending = answers.size();

   always @(posedge clock) begin
      answer_t want, got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_resp_kind, rsp_weight_sum, rsp_weight_scaled,
                    rsp_patterns_stored, rsp_overflow_flag};
            if (answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response kind=%0d sum=%0d scaled=%0d",
                           got.kind, got.sum, got.scaled);
            end else begin
               want = answers.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp kind=%0d sum=%0d scaled=%0d stored=%0d ovf=%0d",
                               " got kind=%0d sum=%0d scaled=%0d stored=%0d ovf=%0d"},
                              want.kind, want.sum, want.scaled, want.stored, want.ovf,
                              got.kind, got.sum, got.scaled, got.stored, got.ovf);
               end
            end
         end
         if (csr_valid && csr_ready) divisor = csr_pattern_count;
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_TRAIN: learn_pixel(req_pixel_value);
               REQ_READ:  read_weight(req_row_index, req_col_index);
               REQ_CLEAR: wipe_store();
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== test/hebbian_weight_accumulator_test.sv =====
`timescale 1ns / 100ps

module hebbian_weight_accumulator_test;
   import hwa_pkg::*;

   // reset sweep, two clears and ~3 patterns, each a full pass over the weights,
   // times several for stalls
   localparam int CYCLE_LIMIT = 3_000_000;
   // longest single request (last pixel of a pattern) plus a read
   localparam int DRAIN_CYCLES = 400;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_type;
   logic [7:0]        req_pixel_value;
   logic [7:0]        req_row_index;
   logic [7:0]        req_col_index;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_resp_kind;
   logic signed [7:0] rsp_weight_sum;
   logic signed [15:0] rsp_weight_scaled;
   logic [TOT_W-1:0]  rsp_patterns_stored;
   logic              rsp_overflow_flag;
   logic              csr_valid;
   logic              csr_ready;
   logic [PC_W-1:0]   csr_pattern_count;

   int  mismatches;
   int  pending;
   int  cycles;
   int  sent;
   int  settings;
   bit  calm;

   hebbian_weight_accumulator i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_pixel_value, .req_row_index,
      .req_col_index,
      .rsp_valid, .rsp_ready, .rsp_resp_kind, .rsp_weight_sum, .rsp_weight_scaled,
      .rsp_patterns_stored, .rsp_overflow_flag,
      .csr_valid, .csr_ready, .csr_pattern_count
   );

   hebbian_weight_accumulator_check i_check (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: stall about 38 percent of cycles except in calm stretches
   always @(posedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 38);

   // issue one request, optionally idle first, then hold until it is taken
   task automatic send(input logic [1:0] kind, input logic [7:0] pix,
                       input logic [7:0] row, input logic [7:0] col);
      if (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_pixel_value <= pix;
      req_row_index   <= row;
      req_col_index   <= col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // wait for the block to go quiet, then write the pattern count
   task automatic set_count(input logic [PC_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_pattern_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd127;
         2: return 8'd128;
         3: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly training pixels so whole patterns complete; reads and drops mixed in
   task automatic random_requests(input int count);
      int  roll;
      int  r;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         r = $urandom_range(255);
         if (roll < 80)
            send(REQ_TRAIN, pick_pixel(), 8'($urandom), 8'($urandom));
         else if (roll < 96)
            send(REQ_READ, 8'($urandom), 8'(r),
                 ($urandom_range(9) == 0) ? 8'(r) : 8'($urandom_range(255)));
         else
            send(2'd3, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      logic [PC_W-1:0] counts [4];
      bit              failed;
      counts = '{7'd64, 7'd0, 7'd127, 7'd3};
      reset             = 1'b1;
      calm              = 1'b0;
      cycles            = 0;
      sent              = 0;
      settings          = 0;
      req_valid         = 1'b0;
      req_type          = REQ_TRAIN;
      req_pixel_value   = '0;
      req_row_index     = '0;
      req_col_index     = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_pattern_count = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_count(7'd1);

      // directed: diagonal, corner indexes, dropped code, clear on empty store
      send(REQ_READ, 8'd0, 8'd0, 8'd0);
      send(REQ_READ, 8'd255, 8'd255, 8'd255);
      send(REQ_READ, 8'd0, 8'd255, 8'd0);
      send(REQ_READ, 8'd0, 8'd0, 8'd255);
      send(2'd3, 8'd255, 8'd255, 8'd255);
      send(2'd3, 8'd0, 8'd0, 8'd0);
      send(REQ_CLEAR, 8'd0, 8'd0, 8'd0);
      send(REQ_TRAIN, 8'd127, 8'd0, 8'd0);
      send(REQ_TRAIN, 8'd128, 8'd0, 8'd0);
      send(REQ_TRAIN, 8'd0, 8'd0, 8'd0);
      send(REQ_TRAIN, 8'd255, 8'd0, 8'd0);
      send(REQ_READ, 8'd0, 8'd1, 8'd0);
      send(REQ_READ, 8'd0, 8'd0, 8'd3);
      send(REQ_READ, 8'd0, 8'd3, 8'd2);

      random_requests(230);
      set_count(counts[0]);
      calm = 1'b1;
      random_requests(110);
      calm = 1'b0;
      random_requests(100);
      set_count(counts[1]);
      send(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      random_requests(200);
      set_count(counts[2]);
      random_requests(100);
      set_count(counts[3]);
      random_requests(100);

      // drain and give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      failed = (mismatches != 0) || (pending != 0);
      $display("covered %0d requests (train, read, clear, dropped) over %0d count settings",
               sent, settings);
      $display("%0d mismatches, %0d responses left over", mismatches, pending);
      if (!failed)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
